// ===== rtl/core/sffr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sffr_pkg
// Shared types, constants and the crc helper of the frame field rewriter.
// ----------------------------------------------------------------------------
package sffr_pkg;

  localparam int MAX_FIELD_BYTES = 8;
  localparam int QUEUE_DEPTH     = 2;

  localparam int BYTE_W   = 8;
  localparam int POS_W    = 16;
  localparam int FB_W     = 4;
  localparam int VALUE_W  = 64;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W    = 64;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_REWRITE_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_OFFSET   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_BYTES    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_VALUE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAME_LEN  = 3'd4;

  localparam logic [POS_W-1:0]  MIN_FRAME_LEN_RST = 16'd16;
  localparam logic [BYTE_W-1:0] SYNC_BYTE         = 8'hAA;
  localparam logic [BYTE_W-1:0] FRAME_TYPE_MASK   = 8'h70;
  localparam logic [15:0]       CRC_INIT          = 16'hFFFF;
  localparam logic [15:0]       CRC_POLY          = 16'h1021;

  typedef enum logic [1:0] {
    KIND_PASS   = 2'd0,
    KIND_CRC_HI = 2'd1,
    KIND_CRC_LO = 2'd2
  } sffr_kind_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    sffr_kind_t        kind;
    logic              fold;
    logic              last;
    logic              modified;
  } sffr_item_t;

  // crc-16/ccitt-false over one byte, msb first
  function automatic logic [15:0] crc_fold(input logic [15:0] crc_in,
                                           input logic [BYTE_W-1:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/sffr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sffr_front
// Holds the configuration, tracks the frame header and classifies each byte.
// ----------------------------------------------------------------------------
module sffr_front #(
  parameter int MaxFieldBytes = sffr_pkg::MAX_FIELD_BYTES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [sffr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sffr_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [sffr_pkg::BYTE_W-1:0]       s_tdata,
  input  logic                              s_tlast,
  output logic                              item_valid,
  output sffr_pkg::sffr_item_t              item,
  input  logic                              item_ready
);
  import sffr_pkg::*;

  localparam int IdxW = (MaxFieldBytes > 1) ? $clog2(MaxFieldBytes) : 1;
  localparam logic [FB_W-1:0] NbMax = FB_W'(MaxFieldBytes);

  logic               rewrite_enable;
  logic [POS_W-1:0]   field_offset;
  logic [FB_W-1:0]    field_bytes;
  logic [VALUE_W-1:0] replace_value;
  logic [POS_W-1:0]   min_frame_len;

  logic [POS_W-1:0]   pos;
  logic [POS_W-1:0]   frame_length;
  logic               sync_seen;
  logic               frame_is_target;

  logic               accept;
  logic [POS_W-1:0]   len_full;
  logic               target_dec;
  logic               target_now;
  logic [FB_W-1:0]    nb;
  logic [POS_W-1:0]   diff;
  logic               in_field;
  logic [FB_W-1:0]    sel_full;
  logic [IdxW-1:0]    sel;
  logic [BYTE_W-1:0]  field_byte;
  logic               fold_late;

  always_ff @(posedge clk) begin
    if (rst) begin
      rewrite_enable <= 1'b0;
      field_offset   <= '0;
      field_bytes    <= '0;
      replace_value  <= '0;
      min_frame_len  <= MIN_FRAME_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REWRITE_ENABLE: rewrite_enable <= cfg_data[0];
        CFG_FIELD_OFFSET:   field_offset   <= cfg_data[POS_W-1:0];
        CFG_FIELD_BYTES:    field_bytes    <= cfg_data[FB_W-1:0];
        CFG_REPLACE_VALUE:  replace_value  <= cfg_data[VALUE_W-1:0];
        CFG_MIN_FRAME_LEN:  min_frame_len  <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept     = s_tvalid & item_ready;
  assign s_tready   = item_ready;
  assign item_valid = s_tvalid;

  assign len_full   = {frame_length[POS_W-1:BYTE_W], s_tdata};
  assign target_dec = rewrite_enable && sync_seen && (len_full >= min_frame_len) &&
                      (field_offset < len_full);
  assign target_now = (pos == 16'd3) ? target_dec : frame_is_target;

  assign nb       = (field_bytes > NbMax) ? NbMax : field_bytes;
  assign diff     = pos - field_offset;
  assign in_field = (pos < frame_length) && (pos >= field_offset) &&
                    (diff < {{(POS_W-FB_W){1'b0}}, nb});
  // most significant used byte goes first
  assign sel_full   = nb - 4'd1 - diff[FB_W-1:0];
  assign sel        = sel_full[IdxW-1:0];
  assign field_byte = replace_value[{sel, 3'b000} +: BYTE_W];
  assign fold_late  = ({1'b0, pos} + 17'd2) < {1'b0, frame_length};

  always_comb begin
    item.data     = s_tdata;
    item.kind     = KIND_PASS;
    item.fold     = 1'b1;
    item.last     = s_tlast;
    item.modified = s_tlast & target_now;
    if (pos > 16'd3) begin
      item.fold = fold_late;
      if (frame_is_target) begin
        if ((frame_length >= 16'd2) && (pos == frame_length - 16'd2)) begin
          item.kind = KIND_CRC_HI;
        end else if ((frame_length >= 16'd1) && (pos == frame_length - 16'd1)) begin
          item.kind = KIND_CRC_LO;
        end else if (in_field) begin
          item.data = field_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos             <= '0;
      frame_length    <= '0;
      sync_seen       <= 1'b0;
      frame_is_target <= 1'b0;
    end else if (accept) begin
      if (s_tlast) begin
        pos             <= '0;
        frame_length    <= '0;
        sync_seen       <= 1'b0;
        frame_is_target <= 1'b0;
      end else begin
        if (pos != {POS_W{1'b1}}) begin
          pos <= pos + 16'd1;
        end
        case (pos)
          16'd0: sync_seen <= (s_tdata == SYNC_BYTE);
          16'd1: begin
            if ((s_tdata & FRAME_TYPE_MASK) != 8'h00) begin
              sync_seen <= 1'b0;
            end
          end
          16'd2: frame_length <= {s_tdata, 8'h00};
          16'd3: begin
            frame_length[BYTE_W-1:0] <= s_tdata;
            frame_is_target          <= target_dec;
          end
          default: ;
        endcase
      end
    end
  end

`ifndef ASSERT_OFF
  a_pos_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tlast) |=> (pos == '0 && !frame_is_target))
    else $error("position not cleared after frame end");
  a_target_fixed: assert property (@(posedge clk) disable iff (rst)
    (accept && !s_tlast && pos > 16'd3) |=> $stable(frame_is_target))
    else $error("target decision changed after header");
`endif

endmodule

// ===== rtl/core/sffr_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sffr_queue
// Short in-order queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module sffr_queue #(
  parameter int Depth = sffr_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  sffr_pkg::sffr_item_t push_item,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output sffr_pkg::sffr_item_t pop_item
);
  import sffr_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr  = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  sffr_item_t      entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;
  logic            pop;

  assign push_ready = (count != DepthCnt);
  assign pop_valid  = (count != '0);
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;
  assign pop_item   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= DepthCnt)
    else $error("queue count out of range");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count missed a push");
`endif

endmodule

// ===== rtl/core/sffr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sffr_back
// Keeps the running crc, inserts crc bytes and drives the output register.
// ----------------------------------------------------------------------------
module sffr_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  sffr_pkg::sffr_item_t        item,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [sffr_pkg::BYTE_W-1:0] m_tdata,   // out_byte
  output logic                        m_tlast,
  output logic                        m_tuser    // frame_modified
);
  import sffr_pkg::*;

  logic [15:0]       running_crc;
  logic [BYTE_W-1:0] ob;
  logic              take;

  assign item_ready = !m_tvalid || m_tready;
  assign take       = item_valid && item_ready;

  always_comb begin
    case (item.kind)
      KIND_CRC_HI: ob = running_crc[15:8];
      KIND_CRC_LO: ob = running_crc[7:0];
      default:     ob = item.data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= CRC_INIT;
      m_tvalid    <= 1'b0;
    end else begin
      if (take) begin
        m_tvalid <= 1'b1;
        if (item.last) begin
          running_crc <= CRC_INIT;
        end else if (item.fold) begin
          running_crc <= crc_fold(running_crc, ob);
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= ob;
      m_tlast <= item.last;
      m_tuser <= item.modified;
    end
  end

`ifndef ASSERT_OFF
  a_crc_restart: assert property (@(posedge clk) disable iff (rst)
    (take && item.last) |=> (running_crc == CRC_INIT))
    else $error("crc not restarted after frame end");
  a_crc_hold: assert property (@(posedge clk) disable iff (rst)
    (take && !item.fold && !item.last) |=> $stable(running_crc))
    else $error("crc moved on an unfolded byte");
`endif

endmodule

// ===== rtl/core/synchrophasor_frame_field_rewrite.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// synchrophasor_frame_field_rewrite
// Byte stream rewriter: replaces a configured field of data frames and
// rewrites the trailing crc-16/ccitt-false.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  s_*       in         tvalid / tready    tdata = data_byte, tlast = last_byte
//  m_*       out        tvalid / tready    tdata = out_byte, tlast = out_last,
//                                          tuser = frame_modified
//  cfg_*     in         we (no wait)       index, data
//
//  one byte per cycle while the output side takes bytes; each byte is registered
//  on its way out (front into the queue, then the crc stage into the output
//  reg)
//  the crc fold of one byte in the back stage sets the per-cycle path
//  synchronous active-high reset, no clearing pass
//  a two-entry queue and the output register let each side stall on its own
// ----------------------------------------------------------------------------
module synchrophasor_frame_field_rewrite #(
  parameter int MaxFieldBytes = sffr_pkg::MAX_FIELD_BYTES,
  parameter int QueueDepth    = sffr_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sffr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sffr_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [sffr_pkg::BYTE_W-1:0]    s_tdata,   // data_byte
  input  logic                           s_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [sffr_pkg::BYTE_W-1:0]    m_tdata,   // out_byte
  output logic                           m_tlast,
  output logic                           m_tuser    // frame_modified
);
  import sffr_pkg::*;

  logic       f_valid;
  logic       f_ready;
  sffr_item_t f_item;
  logic       b_valid;
  logic       b_ready;
  sffr_item_t b_item;

  sffr_front #(
    .MaxFieldBytes(MaxFieldBytes)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .item_valid (f_valid),
    .item       (f_item),
    .item_ready (f_ready)
  );

  sffr_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_item   (b_item)
  );

  sffr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (b_valid),
    .item_ready (b_ready),
    .item       (b_item),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

endmodule
